// ----- hdl/klte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klte_pkg
// shared types, codes and constants of the key list table engine
// ----------------------------------------------------------------------------
package klte_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W         = 32;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 5;
    localparam int CAP_W         = 5;
    localparam int OUT_TDATA_W   = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LSEARCH = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_BSEARCH = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_DUP      = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        POS_NONE   = 2'd0,
        POS_MATCH  = 2'd1,
        POS_APPEND = 2'd2
    } t_pos_sel;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       shift;
        logic       shift_start;
        logic       append;
        logic       dec_count;
        logic       bs_issue;
        logic       bs_update;
        logic       set_res;
        t_status    res_status;
        t_pos_sel   pos_sel;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic hit;
        logic eq;
        logic scan_end;
        logic full;
        logic bs_open;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- hdl/klte_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klte_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module klte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/klte_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klte_datapath
// key store, scan and bisection counters, capacity register and result register
// ----------------------------------------------------------------------------
module klte_datapath #(
    parameter int DEPTH = klte_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  klte_pkg::t_dp_cmd                  i_cmd,
    output klte_pkg::t_dp_stat                 o_stat,
    input  logic [klte_pkg::CMD_W-1:0]         i_in_cmd,
    input  logic [klte_pkg::KEY_W-1:0]         i_in_key,
    input  logic                               i_cfg_we,
    input  logic [klte_pkg::CAP_W-1:0]         i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [klte_pkg::OUT_TDATA_W-1:0]   o_out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ($clog2(DEPTH + 1) > klte_pkg::POS_W) ?
                        $clog2(DEPTH + 1) : klte_pkg::POS_W;
    localparam int PADW = klte_pkg::OUT_TDATA_W - klte_pkg::STATUS_W - 2 * klte_pkg::POS_W;

    logic [klte_pkg::CAP_W-1:0]    r_cap;
    logic [CW-1:0]                 r_count;
    logic                          r_out_valid;
    klte_pkg::t_cmd                r_cmd;
    logic [klte_pkg::KEY_W-1:0]    r_key;
    logic [CW-1:0]                 r_idx;
    logic [CW-1:0]                 r_cmp_idx;
    logic                          r_pend;
    logic                          r_first;
    logic [CW-1:0]                 r_lo;
    logic [CW-1:0]                 r_hx;
    klte_pkg::t_status             r_status;
    logic [CW-1:0]                 r_pos;
    logic [klte_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [CW-1:0]                 n_pos;
    logic [CW-1:0]                 lim;
    logic [CW-1:0]                 cap_ext;
    logic [CW-1:0]                 mid;
    logic [klte_pkg::KEY_W-1:0]    rdata;
    logic [AW-1:0]                 raddr;
    logic [AW-1:0]                 waddr;
    logic [klte_pkg::KEY_W-1:0]    wdata;
    logic                          we;
    logic                          step_any;
    logic                          eq;
    logic                          lt;

    assign cap_ext  = CW'(r_cap);
    assign lim      = (cap_ext < CW'(DEPTH)) ? cap_ext : CW'(DEPTH);
    assign mid      = r_lo + ((r_hx - CW'(1) - r_lo) >> 1);
    assign step_any = i_cmd.step | i_cmd.shift;
    assign eq       = (rdata == r_key);
    assign lt       = $signed(rdata) < $signed(r_key);

    assign raddr = i_cmd.bs_issue ? mid[AW-1:0] : r_idx[AW-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = r_count[AW-1:0];
        wdata = r_key;
        if (i_cmd.append) begin
            we = 1'b1;
        end else if (i_cmd.shift && r_pend) begin
            we    = 1'b1;
            waddr = AW'(r_cmp_idx - CW'(1));
            wdata = rdata;
        end
    end

    klte_ram #(
        .WIDTH (klte_pkg::KEY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= klte_pkg::CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        unique case (i_cmd.pos_sel)
            klte_pkg::POS_MATCH:  n_pos = r_cmp_idx + CW'(1);
            klte_pkg::POS_APPEND: n_pos = r_count + CW'(1);
            default:              n_pos = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= klte_pkg::t_cmd'(i_in_cmd);
            r_key   <= i_in_key;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_first <= 1'b1;
            r_lo    <= '0;
            r_hx    <= r_count;
        end else if (i_cmd.shift_start) begin
            r_idx   <= r_cmp_idx + CW'(1);
            r_pend  <= 1'b0;
            r_first <= 1'b1;
        end else if (step_any) begin
            r_idx     <= r_idx + CW'(1);
            r_cmp_idx <= r_idx;
            r_pend    <= (r_idx < r_count);
            r_first   <= 1'b0;
        end else if (i_cmd.bs_issue) begin
            r_cmp_idx <= mid;
        end else if (i_cmd.bs_update) begin
            if (lt) begin
                r_lo <= r_cmp_idx + CW'(1);
            end else begin
                r_hx <= r_cmp_idx;
            end
        end
        if (i_cmd.set_res) begin
            r_status <= i_cmd.res_status;
            r_pos    <= n_pos;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {{PADW{1'b0}}, r_count[klte_pkg::POS_W-1:0],
                           r_pos[klte_pkg::POS_W-1:0], r_status};
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.hit      = r_pend & eq;
    assign o_stat.eq       = eq;
    assign o_stat.scan_end = ~r_pend & ~r_first;
    assign o_stat.full     = (r_count >= lim);
    assign o_stat.bs_open  = (r_lo < r_hx);
    assign o_stat.out_free = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- hdl/klte_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klte_ctrl
// command sequencer for scan, shift-down removal and bisection
// ----------------------------------------------------------------------------
module klte_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  klte_pkg::t_dp_stat  i_stat,
    output klte_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_BRD   = 6'b001000,
        S_BCMP  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.cmd == klte_pkg::CMD_BSEARCH) begin
                    n_state = S_BRD;
                end else if (i_stat.cmd == klte_pkg::CMD_INSERT && i_stat.full) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = klte_pkg::ST_FULL;
                    o_cmd.pos_sel    = klte_pkg::POS_NONE;
                    n_state          = S_DONE;
                end else if (i_stat.hit) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.pos_sel = klte_pkg::POS_MATCH;
                    unique case (i_stat.cmd)
                        klte_pkg::CMD_INSERT: begin
                            o_cmd.res_status = klte_pkg::ST_DUP;
                            n_state          = S_DONE;
                        end
                        klte_pkg::CMD_REMOVE: begin
                            o_cmd.res_status  = klte_pkg::ST_OK;
                            o_cmd.shift_start = 1'b1;
                            n_state           = S_SHIFT;
                        end
                        default: begin
                            o_cmd.res_status = klte_pkg::ST_OK;
                            n_state          = S_DONE;
                        end
                    endcase
                end else if (i_stat.scan_end) begin
                    o_cmd.set_res = 1'b1;
                    if (i_stat.cmd == klte_pkg::CMD_INSERT) begin
                        o_cmd.append     = 1'b1;
                        o_cmd.res_status = klte_pkg::ST_OK;
                        o_cmd.pos_sel    = klte_pkg::POS_APPEND;
                    end else begin
                        o_cmd.res_status = klte_pkg::ST_NOTFOUND;
                        o_cmd.pos_sel    = klte_pkg::POS_NONE;
                    end
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.scan_end) begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_BRD: begin
                if (i_stat.bs_open) begin
                    o_cmd.bs_issue = 1'b1;
                    n_state        = S_BCMP;
                end else begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = klte_pkg::ST_NOTFOUND;
                    o_cmd.pos_sel    = klte_pkg::POS_NONE;
                    n_state          = S_DONE;
                end
            end
            S_BCMP: begin
                if (i_stat.eq) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = klte_pkg::ST_OK;
                    o_cmd.pos_sel    = klte_pkg::POS_MATCH;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.bs_update = 1'b1;
                    n_state         = S_BRD;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/key_list_table_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_list_table_engine
// packed list of signed keys with linear search, insert, remove, binary search
//
// input items arrive on the s_axis channel: tuser carries the command, tdata
// the key. every item yields one result item on the m_axis channel holding
// status, 1-based position and the count after the command.
// the capacity limit is written over the cfg channel, which is always ready.
// an item is worked on in one sequencer over a key ram with a single read port:
// a linear scan walks one entry per cycle until a hit or the end of the list;
// a remove that hits position p then shifts the later entries down one place;
// binary search takes a read state and a compare state per probe, up to
// log2(count) + 1 probes; a refused insert on a full list skips the scan.
// the next item is taken once the result sits in the output register, so a
// stalled receiver holds one result while the next item is worked on; a
// second result then waits in the sequencer until the output is taken.
// reset empties the list and sets the capacity limit to 16; key ram contents
// are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
module key_list_table_engine #(
    parameter int DEPTH = klte_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [klte_pkg::KEY_W-1:0]         i_s_axis_tdata,   // key
    input  logic [klte_pkg::CMD_W-1:0]         i_s_axis_tuser,   // command
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [klte_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,   // status, position, count, pad
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [klte_pkg::CAP_W-1:0]         i_cfg_data
);

    klte_pkg::t_dp_cmd  dp_cmd;
    klte_pkg::t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    klte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    klte_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_cmd    (i_s_axis_tuser),
        .i_in_key    (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
